/* hw/rtl/hse_pkg.sv */
// Shared types of the heap sort engine: sequencer states and memory port controls.
`timescale 1ns / 1ps
package hse_pkg;

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    ST_LOAD     = 13'b0000000000001,
    ST_SD_RD    = 13'b0000000000010,
    ST_SD_GET   = 13'b0000000000100,
    ST_CMP_L    = 13'b0000000001000,
    ST_CMP_R    = 13'b0000000010000,
    ST_MOVE     = 13'b0000000100000,
    ST_FIN      = 13'b0000001000000,
    ST_XS_RD0   = 13'b0000010000000,
    ST_XS_RDI   = 13'b0000100000000,
    ST_XS_WR    = 13'b0001000000000,
    ST_OUT_RD   = 13'b0010000000000,
    ST_OUT_GET  = 13'b0100000000000,
    ST_OUT_WAIT = 13'b1000000000000
  } state_t;

  // Element memory port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

/* hw/rtl/hse_if.sv */
// Handshake channel interfaces of the heap sort engine: input words and sorted result words.
`timescale 1ns / 1ps
interface hse_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;
  logic                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface hse_out_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sorted_value;
  logic                last_out;
  logic                dropped;

  modport source (output valid, output sorted_value, output last_out, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input dropped,
                  output ready);
endinterface

/* hw/rtl/hse_mem.sv */
// Element store of the heap sort engine: one write port, one registered read port.
`timescale 1ns / 1ps
module hse_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 32,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  hse_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [DW-1:0]     wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DW-1:0]     rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/hse_ctrl.sv */
// Heap sort sequencer: loading, sift-down with one shared comparator, and result output.
`timescale 1ns / 1ps
module hse_ctrl #(
  parameter int CAPACITY = 64,
  parameter int DW       = 32,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DW-1:0]     in_value,
  input  logic              in_last,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DW-1:0]     out_value,
  output logic              out_last,
  output logic              out_dropped,
  // element memory
  output hse_pkg::mem_ctl_t ctl,
  output logic [AW-1:0]     waddr,
  output logic [DW-1:0]     wdata,
  output logic [AW-1:0]     raddr,
  input  logic [DW-1:0]     rdata
);

  localparam int IW = AW + 2;

  hse_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          sort_r, sort_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [AW-1:0] big_r, big_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [DW-1:0] nv_r, nv_nxt;
  logic [DW-1:0] bv_r, bv_nxt;
  logic          ov_r, ov_nxt;
  logic [DW-1:0] od_r, od_nxt;
  logic          ol_r, ol_nxt;
  logic          odr_r, odr_nxt;

  logic [IW-1:0] lc, rc, blc, size_w;
  logic [CW-1:0] cnt_inc, n_new;
  logic [DW-1:0] cmp_b;
  logic          gt;
  logic          k_final;
  logic          in_acc;

  assign lc      = {1'b0, node_r, 1'b1};
  assign rc      = lc + IW'(1);
  assign blc     = {1'b0, big_r, 1'b1};
  assign size_w  = IW'(size_r);
  assign cnt_inc = cnt_r + CW'(1);
  assign k_final = (CW'(k_r) == cnt_r - CW'(1));
  assign in_acc  = in_valid && in_ready;

  // Shared comparator: left child against node, right child against the larger so far
  assign cmp_b = (st_r == hse_pkg::ST_CMP_L) ? nv_r : bv_r;
  assign gt    = $signed(rdata) > $signed(cmp_b);

  assign in_ready    = (st_r == hse_pkg::ST_LOAD);
  assign out_valid   = ov_r;
  assign out_value   = od_r;
  assign out_last    = ol_r;
  assign out_dropped = odr_r;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    sort_nxt  = sort_r;
    idx_nxt   = idx_r;
    size_nxt  = size_r;
    node_nxt  = node_r;
    big_nxt   = big_r;
    k_nxt     = k_r;
    nv_nxt    = nv_r;
    bv_nxt    = bv_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    odr_nxt   = odr_r;
    n_new     = cnt_r;
    ctl.wr_en = 1'b0;
    ctl.rd_en = 1'b0;
    waddr     = node_r;
    wdata     = nv_r;
    raddr     = node_r;

    unique case (st_r)
      hse_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(CAPACITY)) begin
            ctl.wr_en = 1'b1;
            waddr     = cnt_r[AW-1:0];
            wdata     = in_value;
            n_new     = cnt_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          cnt_nxt = n_new;
          if (in_last) begin
            if (n_new < CW'(2)) begin
              k_nxt  = '0;
              st_nxt = hse_pkg::ST_OUT_RD;
            end else begin
              sort_nxt = 1'b0;
              idx_nxt  = n_new >> 1;
              node_nxt = AW'((n_new >> 1) - CW'(1));
              size_nxt = n_new;
              st_nxt   = hse_pkg::ST_SD_RD;
            end
          end
        end
      end
      hse_pkg::ST_SD_RD: begin
        ctl.rd_en = 1'b1;
        raddr     = node_r;
        st_nxt    = hse_pkg::ST_SD_GET;
      end
      hse_pkg::ST_SD_GET: begin
        nv_nxt = rdata;
        if (lc < size_w) begin
          ctl.rd_en = 1'b1;
          raddr     = lc[AW-1:0];
          st_nxt    = hse_pkg::ST_CMP_L;
        end else begin
          st_nxt = hse_pkg::ST_FIN;
        end
      end
      hse_pkg::ST_CMP_L: begin
        if (gt) begin
          big_nxt = lc[AW-1:0];
          bv_nxt  = rdata;
        end else begin
          big_nxt = node_r;
          bv_nxt  = nv_r;
        end
        if (rc < size_w) begin
          ctl.rd_en = 1'b1;
          raddr     = rc[AW-1:0];
          st_nxt    = hse_pkg::ST_CMP_R;
        end else begin
          st_nxt = hse_pkg::ST_MOVE;
        end
      end
      hse_pkg::ST_CMP_R: begin
        if (gt) begin
          big_nxt = rc[AW-1:0];
          bv_nxt  = rdata;
        end
        st_nxt = hse_pkg::ST_MOVE;
      end
      hse_pkg::ST_MOVE: begin
        ctl.wr_en = 1'b1;
        waddr     = node_r;
        if (big_r == node_r) begin
          wdata = nv_r;
        end else begin
          // move the larger child up; the carried value sinks one level
          wdata    = bv_r;
          node_nxt = big_r;
          if (blc < size_w) begin
            ctl.rd_en = 1'b1;
            raddr     = blc[AW-1:0];
            st_nxt    = hse_pkg::ST_CMP_L;
          end else begin
            st_nxt = hse_pkg::ST_FIN;
          end
        end
      end
      hse_pkg::ST_FIN: begin
        ctl.wr_en = 1'b1;
        waddr     = node_r;
        wdata     = nv_r;
      end
      hse_pkg::ST_XS_RD0: begin
        ctl.rd_en = 1'b1;
        raddr     = '0;
        st_nxt    = hse_pkg::ST_XS_RDI;
      end
      hse_pkg::ST_XS_RDI: begin
        bv_nxt    = rdata;
        ctl.rd_en = 1'b1;
        raddr     = idx_r[AW-1:0];
        st_nxt    = hse_pkg::ST_XS_WR;
      end
      hse_pkg::ST_XS_WR: begin
        // old root goes to the end; old end value sifts down from the root
        ctl.wr_en = 1'b1;
        waddr     = idx_r[AW-1:0];
        wdata     = bv_r;
        nv_nxt    = rdata;
        node_nxt  = '0;
        size_nxt  = idx_r;
        if (idx_r > CW'(1)) begin
          ctl.rd_en = 1'b1;
          raddr     = AW'(1);
          st_nxt    = hse_pkg::ST_CMP_L;
        end else begin
          st_nxt = hse_pkg::ST_FIN;
        end
      end
      hse_pkg::ST_OUT_RD: begin
        ctl.rd_en = 1'b1;
        raddr     = k_r;
        st_nxt    = hse_pkg::ST_OUT_GET;
      end
      hse_pkg::ST_OUT_GET: begin
        ov_nxt  = 1'b1;
        od_nxt  = rdata;
        ol_nxt  = k_final;
        odr_nxt = k_final && ovf_r;
        st_nxt  = hse_pkg::ST_OUT_WAIT;
      end
      hse_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          if (k_final) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            st_nxt  = hse_pkg::ST_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            ctl.rd_en = 1'b1;
            raddr     = k_r + AW'(1);
            st_nxt    = hse_pkg::ST_OUT_GET;
          end
        end
      end
      default: begin
        st_nxt = hse_pkg::ST_LOAD;
      end
    endcase

    // End of one sift-down: advance the build or the extraction loop
    if ((st_r == hse_pkg::ST_FIN) ||
        ((st_r == hse_pkg::ST_MOVE) && (big_r == node_r))) begin
      if (idx_r == CW'(1)) begin
        if (sort_r) begin
          k_nxt  = '0;
          st_nxt = hse_pkg::ST_OUT_RD;
        end else begin
          sort_nxt = 1'b1;
          idx_nxt  = cnt_r - CW'(1);
          st_nxt   = hse_pkg::ST_XS_RD0;
        end
      end else begin
        idx_nxt = idx_r - CW'(1);
        if (sort_r) begin
          st_nxt = hse_pkg::ST_XS_RD0;
        end else begin
          node_nxt = AW'(idx_r - CW'(2));
          st_nxt   = hse_pkg::ST_SD_RD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= hse_pkg::ST_LOAD;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      sort_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      sort_r <= sort_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    size_r <= size_nxt;
    node_r <= node_nxt;
    big_r  <= big_nxt;
    k_r    <= k_nxt;
    nv_r   <= nv_nxt;
    bv_r   <= bv_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
    odr_r  <= odr_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_drop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_last)
    else $error("dropped flag on a word that is not the last");

  a_sift_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en && (st_r == hse_pkg::ST_MOVE || st_r == hse_pkg::ST_FIN ||
                  st_r == hse_pkg::ST_XS_WR)
    |-> CW'(waddr) < size_r)
    else $error("sift write outside the heap");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && cnt_r == '0 && !ovf_r)
    else $error("run not cleared after final word");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");

endmodule

/* hw/rtl/heap_sort_engine.sv */
// Top level of the heap sort engine: sequencer and element memory behind two channels.
`timescale 1ns / 1ps
// Usage:
//   in_bus  carries one signed word per transfer (value) plus last. Words are
//           stored in arrival order, one per cycle, while in_bus.ready is high.
//           Up to CAPACITY words are kept; extra words are dropped and noted.
//   The word with last set starts the sort of what was stored (n words).
//   Sorting is a heapsort done by one comparator on a memory with one write
//   port and one registered read port: each sift-down level steps through
//   a left child compare, a right child compare and a write that also starts
//   the next read, since the memory has only one read port.
//   out_bus then returns the n words in ascending order; last_out marks the
//   final word and dropped on that word reports discarded input.
//   in_bus.ready is low from the last input word until the final result word
//   is taken. A stalled out_bus holds its word and the sequencer waits.
//   Reset (rst_n low, synchronous) empties the set; memory contents are
//   not cleared and need not be.
module heap_sort_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  hse_in_if.sink    in_bus,
  hse_out_if.source out_bus
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  hse_pkg::mem_ctl_t       mem_ctl;
  logic [AW-1:0]           mem_waddr;
  logic [DATA_WIDTH-1:0]   mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_rdata;
  logic [DATA_WIDTH-1:0]   res_value;

  hse_ctrl #(
    .CAPACITY (CAPACITY),
    .DW       (DATA_WIDTH),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_value    (in_bus.value),
    .in_last     (in_bus.last),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_value   (res_value),
    .out_last    (out_bus.last_out),
    .out_dropped (out_bus.dropped),
    .ctl         (mem_ctl),
    .waddr       (mem_waddr),
    .wdata       (mem_wdata),
    .raddr       (mem_raddr),
    .rdata       (mem_rdata)
  );

  assign out_bus.sorted_value = $signed(res_value);

  hse_mem #(
    .DEPTH (CAPACITY),
    .DW    (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* sim/hse_sort_checker.sv */
// Checker of the heap sort engine: tracks each loaded set and compares the sorted words.
`timescale 1ns / 1ps
module hse_sort_checker #(
  parameter int CAPACITY = 64,
  parameter int W        = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [W-1:0] in_value,
  input  logic                in_last,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [W-1:0] out_sorted_value,
  input  logic                out_last_out,
  input  logic                out_dropped,
  output int                  fail_count,
  output int                  words_due
);

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                last_out;
    logic                dropped;
  } sorted_word_t;

  sorted_word_t        sorted_words_due[$];
  logic signed [W-1:0] set_store[CAPACITY];
  int unsigned         set_count;
  bit                  overflow_seen;

  function automatic void sift_down(int unsigned size, int unsigned node);
    int unsigned         big;
    int unsigned         lc;
    int unsigned         rc;
    logic signed [W-1:0] t;
    while (node < size) begin
      big = node;
      lc  = 2 * node + 1;
      rc  = 2 * node + 2;
      if (lc < size && set_store[lc] > set_store[big]) big = lc;
      if (rc < size && set_store[rc] > set_store[big]) big = rc;
      if (big == node) break;
      t               = set_store[node];
      set_store[node] = set_store[big];
      set_store[big]  = t;
      node            = big;
    end
  endfunction

  function automatic void heapsort_set(int unsigned n);
    int unsigned         i;
    logic signed [W-1:0] t;
    if (n < 2) return;
    for (i = n / 2; i > 0; i--) sift_down(n, i - 1);
    for (i = n - 1; i > 0; i--) begin
      t            = set_store[0];
      set_store[0] = set_store[i];
      set_store[i] = t;
      sift_down(i, 0);
    end
  endfunction

  function automatic void report(string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    sorted_word_t exp_w;
    int unsigned  k;
    if (!rst_n) begin
      sorted_words_due.delete();
      set_count     = 0;
      overflow_seen = 0;
      fail_count    = 0;
    end else begin
      // check outgoing word before a new set can add expectations
      if (out_valid && out_ready) begin
        if (sorted_words_due.size() == 0) begin
          report($sformatf("unexpected sorted word: %0d last %0b dropped %0b",
                           out_sorted_value, out_last_out, out_dropped));
        end else begin
          exp_w = sorted_words_due.pop_front();
          if (out_sorted_value !== exp_w.value || out_last_out !== exp_w.last_out ||
              out_dropped !== exp_w.dropped) begin
            report($sformatf("sorted word mismatch: expected %0d last %0b dropped %0b, got %0d last %0b dropped %0b",
                             exp_w.value, exp_w.last_out, exp_w.dropped,
                             out_sorted_value, out_last_out, out_dropped));
          end
        end
      end
      if (in_valid && in_ready) begin
        // drop words once the store is full
        if (set_count < CAPACITY) begin
          set_store[set_count] = in_value;
          set_count++;
        end else begin
          overflow_seen = 1;
        end
        if (in_last) begin
          heapsort_set(set_count);
          for (k = 0; k < set_count; k++) begin
            exp_w.value    = set_store[k];
            exp_w.last_out = (k + 1 == set_count);
            exp_w.dropped  = (k + 1 == set_count) && overflow_seen;
            sorted_words_due.push_back(exp_w);
          end
          set_count     = 0;
          overflow_seen = 0;
        end
      end
    end
    words_due = sorted_words_due.size();
  end

endmodule

/* sim/heap_sort_engine_test.sv */
// Top of the heap sort engine testbench: clock, reset, set stimulus, stalls and verdict.
`timescale 1ns / 1ps
module heap_sort_engine_test;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 3000;

  localparam int RX_RANDOM = 0;
  localparam int RX_HOLD   = 1;
  localparam int RX_OPEN   = 2;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   words_due;
  int   rx_mode;
  int   sent_words;
  int   set_no;
  int   set_size;
  bit   calm;

  hse_in_if  #(.W(DATA_WIDTH)) in_ch ();
  hse_out_if #(.W(DATA_WIDTH)) out_ch ();

  heap_sort_engine #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  hse_sort_checker #(
    .CAPACITY(CAPACITY),
    .W       (DATA_WIDTH)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_value        (in_ch.value),
    .in_last         (in_ch.last),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_sorted_value(out_ch.sorted_value),
    .out_last_out    (out_ch.last_out),
    .out_dropped     (out_ch.dropped),
    .fail_count      (fail_count),
    .words_due       (words_due)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          default: return -1;
        endcase
      end
      1: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // call with the clock just past a rising edge; returns at the accepting edge
  task automatic send_word(input logic signed [DATA_WIDTH-1:0] v, input logic is_last,
                           input bit gaps);
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  task automatic send_set(input int n, input bit gaps);
    for (int i = 0; i < n; i++) send_word(pick_value(), i == n - 1, gaps);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (words_due == 0);
  endtask

  // result side: random stall bursts, one long hold-off, open at the end
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_mode == RX_OPEN) begin
        out_ch.ready <= 1'b1;
      end else if (rx_mode == RX_HOLD) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        if (rx_mode == RX_HOLD) rx_mode = RX_RANDOM;
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end
    end
  end

  // end the run if nothing moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    rx_mode     = RX_RANDOM;
    sent_words  = 0;
    calm        = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-word set
    send_word(0, 1'b1, 1'b0);
    // extremes of the signed range
    send_word(32'sh7fff_ffff, 1'b0, 1'b0);
    send_word(32'sh8000_0000, 1'b0, 1'b0);
    send_word(-1, 1'b0, 1'b0);
    send_word(0, 1'b0, 1'b0);
    send_word(1, 1'b1, 1'b0);
    // equal values
    send_word(5, 1'b0, 1'b0);
    send_word(5, 1'b0, 1'b0);
    send_word(-5, 1'b0, 1'b0);
    send_word(5, 1'b1, 1'b0);
    // alternating bit patterns, descending pair
    send_word(32'shaaaa_aaaa, 1'b0, 1'b0);
    send_word(32'sh5555_5555, 1'b0, 1'b0);
    send_word(7, 1'b1, 1'b0);
    send_word(9, 1'b0, 1'b0);
    send_word(-9, 1'b1, 1'b0);

    set_no = 0;
    while (sent_words < 305) begin
      calm = (sent_words >= 275);
      if (calm) rx_mode = RX_OPEN;
      case (set_no)
        2:  set_size = CAPACITY;
        6:  set_size = CAPACITY + 1;
        10: set_size = CAPACITY + 6;
        default: begin
          if ($urandom_range(0, 11) == 0) set_size = CAPACITY - 2 + $urandom_range(0, 6);
          else set_size = $urandom_range(1, 12);
        end
      endcase
      // hold the result side while this set and the next are offered
      if (set_no == 4 && !calm) rx_mode = RX_HOLD;
      send_set(set_size, !calm);
      if (set_no == 8) drain_results();
      set_no++;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (words_due == 0);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && words_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
